// ===== design/jde_pkg.sv =====
// jde_pkg: shared types, constants and command/status structs for the
// jitter depth estimator. No dependencies.
package jde_pkg;

  localparam int WINDOW = 15;
  localparam int WIN_IDX_W = 4;   // index bits for WINDOW entries
  localparam int WIN_CNT_W = 4;   // count bits, holds 0..WINDOW
  localparam int SUM_W = 37;

  localparam logic [9:0] NET_DECAY_RESET = 10'd995;
  localparam logic [9:0] PERMILLE_ONE = 10'd1000;

  // ceil(2^28 / 1000): exact quotient for 18-bit digit dividends
  localparam logic [18:0] RECIP_1000 = 19'd268436;

  localparam logic [2:0] TREND_DOWN_SLOW = 3'd1;
  localparam logic [2:0] TREND_DOWN_FAST = 3'd2;
  localparam logic [2:0] TREND_UP_SLOW   = 3'd4;
  localparam logic [2:0] TREND_UP_FAST   = 3'd5;

  typedef struct packed {
    logic [31:0] send_time;
    logic [31:0] recv_time;
    logic [2:0]  trend_code;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rel_delay;
    logic signed [31:0] delay_estimate;
    logic signed [31:0] raw_depth;
    logic signed [31:0] buffer_depth;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic delay_upd;  // update acc/peak delay, start peak blend divide
    logic peak_done;  // take peak blend quotient
    logic depth_sel;  // peak-hold or start depth blend divide
    logic depth_done; // take depth blend quotient
    logic win_upd;    // update window, start average divide
    logic avg_done;   // take average, floor, commit depth
  } jde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_busy;
    logic peak_blend; // peak takes the blend path
    logic depth_blend;
  } jde_sts_t;

  // depth decay weight from gap and trend, per mille
  function automatic logic [10:0] depth_weight(input logic signed [32:0] gap,
                                               input logic [2:0] trend);
    logic [10:0] w;
    begin
      if (gap > 33'sd500)      w = 11'd980;
      else if (gap > 33'sd400) w = 11'd985;
      else if (gap > 33'sd300) w = 11'd990;
      else if (gap > 33'sd200) w = 11'd995;
      else if (gap > 33'sd150) w = 11'd998;
      else                     w = 11'd999;
      case (trend)
        TREND_DOWN_SLOW: w = w + 11'd10;
        TREND_DOWN_FAST: w = w - 11'd10;
        TREND_UP_SLOW:   w = w + 11'd10;
        TREND_UP_FAST:   w = w + 11'd20;
        default:         w = w;
      endcase
      return w;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    begin
      if (v > 48'sd2147483647) return 32'sh7fffffff;
      else if (v < -48'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

// ===== design/jitter_depth_estimator.sv =====
// jitter_depth_estimator: top level, controller plus datapath and the
// output register. Depends on jde_pkg, jde_ctrl, jde_datapath.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_data) takes one frame per
//    transaction: send time, receive time and trend code.
//  - Output channel (out_valid/out_stall/out_data) gives one result
//    transaction per frame: instant delay, delay estimate, instant depth
//    and smoothed buffer depth.
//  - cfg_we/cfg_wdata write the network decay weight (per mille); values
//    above 1000 are clamped. Write only while the block is idle.
//  - The two per-mille blends divide by 1000 in 6 reciprocal steps, run
//    only when the blend path is taken; the window average divides by the
//    count bit-serially in 48 steps, which make up most of a frame's work.
//  - One frame is in flight at a time; in_stall is high while it works.
//  - The result sits in an output register. A stalled receiver holds it;
//    the next frame may be accepted and computed meanwhile, and waits only
//    at its final step until the register frees.
//  - Synchronous active-low reset clears state, the depth to zero, the
//    window to empty and the weight to 995.
module jitter_depth_estimator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jde_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jde_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata
);
  jde_pkg::jde_cmd_t  cmd;
  jde_pkg::jde_sts_t  sts;
  jde_pkg::out_item_t res;
  jde_pkg::out_item_t out_r;
  logic               out_load;

  jde_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
    .out_load(out_load)
  );

  jde_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .sts(sts), .res(res)
  );

  // result register, loaded when the previous transaction is gone
  always_ff @(posedge clk) begin
    if (out_load) out_r <= res;
  end

  assign out_data = out_r;
endmodule

// ===== design/jde_ram.sv =====
// jde_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module jde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/jde_div.sv =====
// jde_div: signed divider truncating toward zero. Per-mille mode divides by
// 1000 in six radix-256 reciprocal steps; otherwise one bit per cycle.
// Depends on jde_pkg.
module jde_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               per_mille, // divide by 1000, divisor ignored
  input  logic signed [47:0] dividend,
  input  logic [10:0]        divisor,   // positive, nonzero
  output logic               busy,
  output logic signed [47:0] quotient
);
  logic [47:0] q_r, q_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [10:0] dvs_r;
  logic        neg_r;
  logic        pm_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r;
  logic [48:0] trial;
  logic [17:0] dig_t, dig_r;
  logic [36:0] dig_p;
  logic [7:0]  dig_q;

  always_comb begin
    rem_nxt = {rem_r[46:0], q_r[47]};
    q_nxt   = {q_r[46:0], 1'b0};
    trial   = {1'b0, rem_nxt} - {38'd0, dvs_r};
    if (!trial[48]) begin
      rem_nxt = trial[47:0];
      q_nxt[0] = 1'b1;
    end
    // remainder below 1000 keeps the digit dividend under 2^18
    dig_t = {rem_r[9:0], q_r[47:40]};
    dig_p = 37'(dig_t) * 37'(jde_pkg::RECIP_1000);
    dig_q = dig_p[35:28];
    dig_r = dig_t - 18'(dig_q) * 18'(jde_pkg::PERMILLE_ONE);
    if (pm_r) begin
      rem_nxt = {38'd0, dig_r[9:0]};
      q_nxt   = {q_r[39:0], dig_q};
    end
    cnt_nxt = cnt_r - 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= per_mille ? 6'd6 : 6'd48;
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_nxt == 6'd0) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend[47] ? -dividend : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[47];
      pm_r  <= per_mille;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

// ===== design/jde_datapath.sv =====
// jde_datapath: delay tracking, blends, window store and average.
// Depends on jde_pkg, jde_div, jde_ram.
module jde_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  jde_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata,
  input  jde_pkg::jde_cmd_t  cmd,
  output jde_pkg::jde_sts_t  sts,
  output jde_pkg::out_item_t res
);
  jde_pkg::in_item_t   item_r;
  logic [9:0]          net_w_r;
  logic                started_r;
  logic                peak_blend_r;
  logic signed [32:0]  prev_tr_r;
  logic signed [31:0]  acc_r, peak_r, depth_r, v_r;
  logic signed [36:0]  sum_r;
  logic [jde_pkg::WIN_CNT_W-1:0] cnt_r;
  logic [jde_pkg::WIN_IDX_W-1:0] head_r;

  logic signed [32:0]  transit;
  logic signed [47:0]  acc_wide;
  logic signed [31:0]  acc_new;
  logic signed [47:0]  div_a;
  logic [10:0]         div_b;
  logic                div_pm;
  logic                div_start;
  logic                div_busy;
  logic signed [47:0]  quot;
  logic [10:0]         dw;
  logic [31:0]         old_v;
  logic signed [36:0]  sum_new;
  logic signed [31:0]  avg_sat;

  // two's-complement diff of 32-bit unsigned times
  assign transit  = $signed({1'b0, item_r.recv_time}) - $signed({1'b0, item_r.send_time});
  assign acc_wide = 48'(acc_r) + 48'(transit) - 48'(prev_tr_r);
  assign acc_new  = jde_pkg::sat32(acc_wide);
  assign dw = jde_pkg::depth_weight(33'(depth_r) - 33'(peak_r), item_r.trend_code);

  assign sts.div_busy    = div_busy;
  assign sts.peak_blend  = peak_blend_r;
  assign sts.depth_blend = !(depth_r < peak_r);

  always_comb begin
    div_start = 1'b0;
    div_pm = 1'b0;
    div_a = '0;
    div_b = 11'd1000;
    if (cmd.delay_upd && started_r && !(peak_r < acc_new)) begin
      div_start = 1'b1;
      div_pm = 1'b1;
      div_a = 48'($signed({1'b0, net_w_r})) * 48'(peak_r)
            + 48'($signed(11'd1000 - {1'b0, net_w_r})) * 48'(acc_new);
    end else if (cmd.depth_sel && !(depth_r < peak_r)) begin
      div_start = 1'b1;
      div_pm = 1'b1;
      div_a = 48'($signed({1'b0, dw})) * 48'(depth_r)
            + 48'($signed(11'd1000 - dw)) * 48'(peak_r);
    end else if (cmd.win_upd) begin
      div_start = 1'b1;
      div_a = 48'(sum_new);
      div_b = 11'(cnt_r) + ((cnt_r < 4'(jde_pkg::WINDOW)) ? 11'd1 : 11'd0);
    end
  end

  jde_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .per_mille(div_pm), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(quot)
  );

  // old window entry at head is read while depth work runs
  jde_ram #(.WIDTH(32), .DEPTH(jde_pkg::WINDOW)) u_win (
    .clk(clk), .we(cmd.win_upd), .waddr(head_r), .wdata(v_r),
    .raddr(head_r), .rdata(old_v)
  );

  assign sum_new = (cnt_r < 4'(jde_pkg::WINDOW))
                 ? sum_r + 37'(v_r)
                 : sum_r - 37'($signed(old_v)) + 37'(v_r);
  assign avg_sat = jde_pkg::sat32(quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_w_r   <= jde_pkg::NET_DECAY_RESET;
      started_r <= 1'b0;
      peak_blend_r <= 1'b0;
      prev_tr_r <= '0;
      acc_r <= '0; peak_r <= '0; depth_r <= '0;
      sum_r <= '0; cnt_r <= '0; head_r <= '0;
    end else begin
      if (cfg_we)
        net_w_r <= (cfg_wdata > jde_pkg::PERMILLE_ONE) ? jde_pkg::PERMILLE_ONE : cfg_wdata;
      if (cmd.delay_upd) begin
        prev_tr_r <= transit;
        started_r <= 1'b1;
        // remembers whether the blend divide was launched for this frame
        peak_blend_r <= started_r && !(peak_r < acc_new);
        if (started_r) begin
          acc_r <= acc_new;
          if (peak_r < acc_new) peak_r <= acc_new;
        end else begin
          acc_r <= '0;
          peak_r <= '0;
        end
      end
      if (cmd.peak_done) peak_r <= jde_pkg::sat32(quot);
      if (cmd.win_upd) begin
        sum_r <= sum_new;
        if (cnt_r < 4'(jde_pkg::WINDOW)) cnt_r <= cnt_r + 4'd1;
        head_r <= (head_r == 4'(jde_pkg::WINDOW - 1)) ? '0 : head_r + 4'd1;
      end
      if (cmd.avg_done)
        depth_r <= (avg_sat < peak_r) ? peak_r : avg_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.depth_sel && (depth_r < peak_r)) v_r <= peak_r;
    if (cmd.depth_done) v_r <= jde_pkg::sat32(quot);
  end

  assign res.rel_delay      = acc_r;
  assign res.delay_estimate = peak_r;
  assign res.raw_depth      = peak_r;
  assign res.buffer_depth   = depth_r;
endmodule

// ===== design/jde_ctrl.sv =====
// jde_ctrl: sequencer for one frame and the output register handshake.
// Depends on jde_pkg.
module jde_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  jde_pkg::jde_sts_t sts,
  output jde_pkg::jde_cmd_t cmd,
  output logic              out_load
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELAY = 3'd1;
  localparam logic [2:0] S_PEAKW = 3'd2;
  localparam logic [2:0] S_DEPTH = 3'd3;
  localparam logic [2:0] S_DEPW  = 3'd4;
  localparam logic [2:0] S_WIN   = 3'd5;
  localparam logic [2:0] S_AVGW  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic       wait_r, wait_nxt; // divider launch state ran last cycle

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    wait_nxt = 1'b0;
    cmd = '0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_DELAY;
      end
      S_DELAY: begin
        cmd.delay_upd = 1'b1;
        state_nxt = S_PEAKW;
        wait_nxt = 1'b1;
      end
      S_PEAKW: if (!wait_r && !sts.div_busy) begin
        cmd.peak_done = sts.peak_blend;
        state_nxt = S_DEPTH;
      end
      S_DEPTH: begin
        cmd.depth_sel = 1'b1;
        state_nxt = S_DEPW;
        wait_nxt = 1'b1;
      end
      S_DEPW: if (!wait_r && !sts.div_busy) begin
        cmd.depth_done = sts.depth_blend;
        state_nxt = S_WIN;
      end
      S_WIN: begin
        cmd.win_upd = 1'b1;
        state_nxt = S_AVGW;
        wait_nxt = 1'b1;
      end
      S_AVGW: if (!wait_r && !sts.div_busy) begin
        cmd.avg_done = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (!ov_nxt) begin
        out_load = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      wait_r  <= wait_nxt;
    end
  end
endmodule

// ===== sim/jitter_depth_estimator_tb.sv =====
// jitter_depth_estimator_tb: self-checking bench for the jitter depth estimator.
// Depends on jde_pkg and the jitter_depth_estimator top level; a scoreboard
// class predicts every result and checks each transaction against it.
`timescale 1ns / 100ps

module jitter_depth_estimator_tb;

  // Depth predictor and queue of expected results.
  class depth_scoreboard;
    int unsigned net_decay;
    bit          started;
    longint      prev_transit, acc_delay, peak_delay, depth_value;
    longint      window_vals[jde_pkg::WINDOW];
    longint      window_sum;
    int unsigned window_count, window_head;
    jde_pkg::out_item_t pending[$];
    int          errors;
    int          checked;

    function void clear();
      net_decay = 995; started = 0; prev_transit = 0; acc_delay = 0;
      peak_delay = 0; depth_value = 0; window_sum = 0; window_count = 0;
      window_head = 0; errors = 0; checked = 0;
      pending.delete();
    endfunction

    function void set_decay(logic [9:0] v);
      net_decay = (v > 10'd1000) ? 1000 : v;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // weighted mean, per mille, truncated toward zero
    function longint mix(longint w, longint held, longint inst);
      return clamp32((w * held + (1000 - w) * inst) / 1000);
    endfunction

    function longint decay_for(logic [2:0] trend);
      longint gap, w;
      gap = depth_value - peak_delay;
      if (gap > 500) w = 980;
      else if (gap > 400) w = 985;
      else if (gap > 300) w = 990;
      else if (gap > 200) w = 995;
      else if (gap > 150) w = 998;
      else w = 999;
      if (trend == jde_pkg::TREND_DOWN_SLOW || trend == jde_pkg::TREND_UP_SLOW) w += 10;
      else if (trend == jde_pkg::TREND_DOWN_FAST) w -= 10;
      else if (trend == jde_pkg::TREND_UP_FAST) w += 20;
      return w;
    endfunction

    function void note_frame(jde_pkg::in_item_t f);
      longint transit, inst, v, avg;
      jde_pkg::out_item_t r;
      transit = longint'(f.recv_time) - longint'(f.send_time);
      if (started) begin
        acc_delay = clamp32(acc_delay + (transit - prev_transit));
        if (peak_delay < acc_delay) peak_delay = acc_delay;
        else peak_delay = mix(longint'(net_decay), peak_delay, acc_delay);
      end else begin
        acc_delay = 0; peak_delay = 0; started = 1;
      end
      prev_transit = transit;
      inst = peak_delay;
      if (depth_value < inst) v = inst;
      else v = mix(decay_for(f.trend_code), depth_value, inst);
      if (window_count < jde_pkg::WINDOW) window_count++;
      else window_sum -= window_vals[window_head];
      window_vals[window_head] = v;
      window_sum += v;
      window_head = (window_head + 1) % jde_pkg::WINDOW;
      avg = window_sum / longint'(window_count);
      if (avg < inst) avg = inst;
      depth_value = clamp32(avg);
      r.rel_delay = acc_delay[31:0];
      r.delay_estimate = peak_delay[31:0];
      r.raw_depth = inst[31:0];
      r.buffer_depth = depth_value[31:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(jde_pkg::out_item_t got);
      jde_pkg::out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", got);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (got.rel_delay !== e.rel_delay) begin
        $error("rel_delay: expected %0d actual %0d", e.rel_delay, got.rel_delay);
        errors++;
      end
      if (got.delay_estimate !== e.delay_estimate) begin
        $error("delay_estimate: expected %0d actual %0d", e.delay_estimate,
               got.delay_estimate);
        errors++;
      end
      if (got.raw_depth !== e.raw_depth) begin
        $error("raw_depth: expected %0d actual %0d", e.raw_depth, got.raw_depth);
        errors++;
      end
      if (got.buffer_depth !== e.buffer_depth) begin
        $error("buffer_depth: expected %0d actual %0d", e.buffer_depth, got.buffer_depth);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000; // idle cycles allowed without a transaction
  localparam int DRAIN_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  jde_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  jde_pkg::out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  depth_scoreboard sb = new();
  int  idle_cycles = 0;
  int  frames_sent = 0;
  bit  rx_quiet = 0;    // receiver starts no new stall bursts while set
  logic [31:0] cur_send = 0;
  logic [31:0] cur_recv = 0;

  jitter_depth_estimator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // Random gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 6);
    return $urandom_range(20, 300);
  endfunction

  // Sample outputs and handshakes at the edge; score results, run watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (in_valid && !in_stall) sb.note_frame(in_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (rx_quiet) out_stall <= 1'b0;
      else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end
    end
  end

  // Present one frame and hold it until accepted; optional gap afterward.
  task automatic send_frame(logic [31:0] s, logic [31:0] r, logic [2:0] t, bit gaps);
    int n;
    in_valid <= 1'b1;
    in_data <= '{send_time: s, recv_time: r, trend_code: t};
    do @(posedge clk); while (in_stall);
    frames_sent++;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (in_valid) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_decay(logic [9:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_decay(v);
  endtask

  // Frame stream with plausible jitter on a moving timeline; occasional noise.
  task automatic random_frames(int count, int jitter_max);
    logic [31:0] s, r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        s = $urandom; r = $urandom;   // wild timestamps, saturation paths
      end else begin
        cur_send = cur_send + $urandom_range(1, 66);
        cur_recv = cur_send + 32'd50 + $urandom_range(0, jitter_max);
        s = cur_send; r = cur_recv;
      end
      send_frame(s, r, 3'($urandom_range(7)), 1'b1);
    end
  endtask

  initial begin
    logic [9:0] decays[6];
    sb.clear();
    decays = '{10'd0, 10'd1000, 10'd1023, 10'd500, 10'd990, 10'd995};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first frame, every trend code, timestamp extremes and wrap.
    rx_quiet = 1;
    send_frame(32'd0, 32'd0, 3'd0, 1'b0);
    for (int t = 0; t < 8; t++)
      send_frame(32'd100 * t, 32'd100 * t + 32'd40 + 32'd90 * (t % 3), t[2:0], 1'b0);
    send_frame(32'd1000, 32'd1900, 3'd0, 1'b0);         // wide transit jump
    for (int t = 0; t < 8; t++) send_frame(32'd1100 + t, 32'd1150, t[2:0], 1'b0);
    send_frame(32'hFFFFFFFF, 32'd0, 3'd5, 1'b0);        // large negative transit
    send_frame(32'd0, 32'hFFFFFFFF, 3'd2, 1'b0);        // large positive jump
    send_frame(32'd0, 32'hFFFFFFFF, 3'd1, 1'b0);
    send_frame(32'hFFFFFFFF, 32'd0, 3'd7, 1'b0);
    for (int i = 0; i < 4; i++)                          // drive delay to saturation
      send_frame(32'd0, (i % 2) ? 32'hFFFFFFFF : 32'd0, 3'd4, 1'b0);
    rx_quiet = 0;
    wait_idle();    // sender holds off until every result is back

    // Random phases under each decay weight, extremes included.
    foreach (decays[k]) begin
      write_decay(decays[k]);
      random_frames(270, (k % 2) ? 900 : 120);
      if (k == 2) rx_quiet = 1;
      if (k == 3) rx_quiet = 0;
      wait_idle();
    end

    $display("covered %0d frames over %0d decay settings with random stalls and gaps;",
             frames_sent, 6);
    $display("%0d result transactions checked", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/jde_pkg.sv
design/jde_ram.sv
design/jde_div.sv
design/jde_datapath.sv
design/jde_ctrl.sv
design/jitter_depth_estimator.sv
sim/jitter_depth_estimator_tb.sv
